// File: rtl/core/spg_pkg.sv
// spg_pkg: shared types, constants and timing helpers of the servo pulse block
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps

package spg_pkg;

  localparam int NUM_CHANNELS_DEF = 24;

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int CH_W   = 5;
  localparam int POS_W  = 16;
  localparam int PIN_W  = 24;
  localparam int CNT_W  = 16;
  localparam int TPU_W  = 5;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END    = 1'd1;

  localparam logic [TPU_W-1:0] TPU_RESET       = 5'd16;
  localparam logic [CNT_W-1:0] FRAME_END_RESET = 16'd44800;

  typedef enum logic [OP_W-1:0] {
    OP_SET_TARGET    = 3'd0,
    OP_START_OUTPUT  = 3'd1,
    OP_START_READ    = 3'd2,
    OP_TICK          = 3'd3,
    OP_READ_CAPTURE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OUT  = 2'd1,
    PH_READ = 2'd2
  } phase_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [CH_W-1:0]  channel;
    logic [POS_W-1:0] target_position;
    logic [PIN_W-1:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0] drive_low;
    logic [1:0]       phase;
    logic [CNT_W-1:0] read_value;
    logic             rejected;
  } result_t;

  // readback window edges in ticks, all mod 2^16
  typedef struct packed {
    logic [CNT_W-1:0] t100;
    logic [CNT_W-1:0] t150;
    logic [CNT_W-1:0] t300;
    logic [CNT_W-1:0] t250;
    logic [CNT_W-1:0] t_end;
    logic [CNT_W-1:0] t_none;
  } windows_t;

  function automatic logic [CNT_W-1:0] scale_us(input logic [11:0] us,
                                                input logic [TPU_W-1:0] tpu);
    logic [16:0] prod;
    prod = 17'(us) * 17'(tpu);
    return prod[CNT_W-1:0];
  endfunction

  function automatic windows_t calc_windows(input logic [TPU_W-1:0] tpu);
    windows_t w;
    w.t100   = scale_us(12'd100, tpu);
    w.t150   = scale_us(12'd150, tpu);
    w.t300   = scale_us(12'd300, tpu);
    w.t250   = scale_us(12'd250, tpu);
    w.t_end  = w.t300 + scale_us(12'd2500, tpu);
    w.t_none = 16'd0 - w.t250;
    return w;
  endfunction

endpackage

// File: rtl/core/spg_cfg.sv
// spg_cfg: configuration registers; readback windows derived at write time
// depends on spg_pkg
`timescale 1ns / 1ps

module spg_cfg import spg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output windows_t             win,
  output logic [CNT_W-1:0]     frame_end_ticks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      win             <= calc_windows(TPU_RESET);
      frame_end_ticks <= FRAME_END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_US: win             <= calc_windows(cfg_data[TPU_W-1:0]);
        CFG_FRAME_END:    frame_end_ticks <= cfg_data[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

endmodule

// File: rtl/core/spg_core.sv
// spg_core: channel state and the single-pass update for one request
// depends on spg_pkg; windows come from spg_cfg
`timescale 1ns / 1ps

module spg_core import spg_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  item_t            item,
  input  windows_t         win,
  input  logic [CNT_W-1:0] frame_end_ticks,
  output result_t          result
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [NUM_CHANNELS-1:0] ALL_CH = '1;

  logic [CNT_W-1:0]        targets  [NUM_CHANNELS];
  logic [CNT_W-1:0]        captures [NUM_CHANNELS];
  logic [CNT_W-1:0]        frame_counter, frame_counter_next;
  phase_e                  frame_phase, frame_phase_next;
  logic [NUM_CHANNELS-1:0] sticky_low, sticky_low_next;
  logic [NUM_CHANNELS-1:0] line_drive, line_drive_next;

  logic [31:0]             pins_wide, drive_wide;
  logic [NUM_CHANNELS-1:0] pins, fresh, reached_zero, reached_inc, cap_we;
  logic [CNT_W-1:0]        cnt_inc, cap_val, rd;
  logic                    ch_ok, busy, tgt_we, rej;
  logic [IDX_W-1:0]        idx;
  op_e                     op;

  assign op        = op_e'(item.operation);
  assign pins_wide = 32'(item.pin_levels);
  assign pins      = pins_wide[NUM_CHANNELS-1:0];
  assign ch_ok     = 32'(item.channel) < NUM_CHANNELS;
  assign idx       = item.channel[IDX_W-1:0];
  assign busy      = frame_phase != PH_IDLE;
  assign cnt_inc   = frame_counter + 16'd1;
  assign fresh     = ~pins & ~sticky_low;

  // two comparators per channel: target against zero and against the next count
  always_comb begin
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      reached_zero[n] = targets[n] == '0;
      reached_inc[n]  = targets[n] <= cnt_inc;
    end
  end

  always_comb begin
    frame_counter_next = frame_counter;
    frame_phase_next   = frame_phase;
    sticky_low_next    = sticky_low;
    line_drive_next    = line_drive;
    tgt_we             = 1'b0;
    cap_we             = '0;
    cap_val            = '0;
    rd                 = '0;
    rej                = 1'b0;
    unique case (op)
      OP_SET_TARGET: begin
        if (busy || !ch_ok) rej = 1'b1;
        else tgt_we = 1'b1;
      end
      OP_START_OUTPUT: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          frame_counter_next = '0;
          frame_phase_next   = PH_OUT;
          line_drive_next    = reached_zero;
        end
      end
      OP_START_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          frame_counter_next = '0;
          frame_phase_next   = PH_READ;
          line_drive_next    = '0;
          sticky_low_next    = '0;
        end
      end
      OP_TICK: begin
        if (frame_phase == PH_OUT) begin
          frame_counter_next = cnt_inc;
          line_drive_next    = line_drive | reached_inc;
          if (cnt_inc >= frame_end_ticks) begin
            line_drive_next  = ALL_CH;
            frame_phase_next = PH_IDLE;
          end
        end else if (frame_phase == PH_READ) begin
          frame_counter_next = cnt_inc;
          priority if (cnt_inc >= win.t_end) begin
            // channels never seen low get the no-pulse value
            cap_we           = ~sticky_low;
            cap_val          = win.t_none;
            line_drive_next  = ALL_CH;
            frame_phase_next = PH_IDLE;
          end else if (cnt_inc >= win.t300) begin
            cap_we          = fresh;
            cap_val         = cnt_inc - win.t250;
            sticky_low_next = sticky_low | fresh;
          end else if (cnt_inc >= win.t150) begin
            line_drive_next = '0;
          end else if (cnt_inc >= win.t100) begin
            line_drive_next = ALL_CH;
          end else begin
            line_drive_next = line_drive;
          end
        end
      end
      OP_READ_CAPTURE: begin
        if (busy || !ch_ok) rej = 1'b1;
        else rd = captures[idx];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      frame_phase   <= PH_IDLE;
      sticky_low    <= '0;
      line_drive    <= ALL_CH;
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        targets[n]  <= '0;
        captures[n] <= '0;
      end
    end else if (fire) begin
      frame_counter <= frame_counter_next;
      frame_phase   <= frame_phase_next;
      sticky_low    <= sticky_low_next;
      line_drive    <= line_drive_next;
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        if (tgt_we && idx == IDX_W'(n)) targets[n] <= item.target_position;
        if (cap_we[n]) captures[n] <= cap_val;
      end
    end
  end

  assign drive_wide        = 32'(line_drive_next);
  assign result.drive_low  = drive_wide[PIN_W-1:0];
  assign result.phase      = frame_phase_next;
  assign result.read_value = rd;
  assign result.rejected   = rej;

endmodule

// File: rtl/core/servo_pulse_generator_readback.sv
// servo_pulse_generator_readback: top level, stream handshake and result register
// depends on spg_pkg, spg_cfg, spg_core
`timescale 1ns / 1ps

// Multi-channel servo pulse generator with readback capture. Each request beat
// (set target, start output frame, start readback, tick, read capture) yields
// exactly one result beat carrying the line drive mask, the frame phase, the
// read value and a reject flag, all as they stand after that request. The block
// sustains one beat per clock while results are taken: a request is held in the
// input register, resolved in one pass over the channel state (per-channel
// target and readback window compares), and lands in the result register.
// Timing advances only on tick beats, so a tick stream at full rate gives one
// counter step per clock. All but tick and spare codes are rejected while a
// frame runs, as are set target and read capture on out-of-range channels.
// Configuration may only be written when no frame is running and no beat is
// in flight; readback window edges are computed when ticks_per_us is written.
module servo_pulse_generator_readback import spg_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // channel, target_position, pin_levels, zero pad
  input  logic [OP_W-1:0]      s_tuser,   // operation
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // drive_low, phase, read_value, zero pad
  output logic                 m_tuser,   // rejected
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [31:0] CH_MASK32 =
      (NUM_CHANNELS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_CHANNELS) - 32'd1);

  item_t            in_item;
  logic             in_valid;
  result_t          out_result, core_result;
  logic             out_valid;
  logic             adv;          // input register hands its beat to the core
  windows_t         win;
  logic [CNT_W-1:0] frame_end_ticks;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation       <= s_tuser;
      in_item.channel         <= s_tdata[4:0];
      in_item.target_position <= s_tdata[20:5];
      in_item.pin_levels      <= s_tdata[44:21];
    end
  end

  spg_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .win             (win),
    .frame_end_ticks (frame_end_ticks)
  );

  spg_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (adv),
    .item            (in_item),
    .win             (win),
    .frame_end_ticks (frame_end_ticks),
    .result          (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_result <= core_result;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_result.read_value, out_result.phase, out_result.drive_low};
  assign m_tuser  = out_result.rejected;

  // a rejected request never returns a capture value
  a_reject_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.rejected |-> out_result.read_value == '0)
    else $error("rejected beat carries a read value");

  // idle is only reached through reset or a frame end, both hold every line low
  a_idle_all_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.phase == PH_IDLE |-> out_result.drive_low == CH_MASK32[PIN_W-1:0])
    else $error("idle result with released lines");

  // a stalled request stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(in_item))
    else $error("input beat lost under stall");

  // every beat handed to the core shows up as a result
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("result beat missing");

endmodule

// File: tb/servo_frame_checker.sv
// servo_frame_checker: keeps its own copy of the servo channel state, works out each result
// beat from the request beats and register writes it sees, and compares field by field
// depends on spg_pkg
`timescale 1ns / 1ps

module servo_frame_checker import spg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [47:0]          s_tdata,   // channel, target_position, pin_levels, zero pad
  input  logic [OP_W-1:0]      s_tuser,   // operation
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [47:0]          m_tdata,   // drive_low, phase, read_value, zero pad
  input  logic                 m_tuser,   // rejected
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);

  localparam int NUM_CH = NUM_CHANNELS_DEF;
  // readback window edges in microseconds
  localparam int US_RELEASE = 100;
  localparam int US_PULL    = 150;
  localparam int US_OFFSET  = 250;
  localparam int US_SAMPLE  = 300;
  localparam int US_SPAN    = 2500;

  logic [POS_W-1:0] target_mem  [NUM_CH];
  logic [CNT_W-1:0] capture_mem [NUM_CH];
  logic [CNT_W-1:0] tick_count;
  phase_e           frame_ph;
  logic [PIN_W-1:0] seen_low;
  logic [PIN_W-1:0] line_mask;
  logic [TPU_W-1:0] tpu_reg;
  logic [CNT_W-1:0] end_reg;

  result_t results_due [$];

  initial begin
    mismatch_count = 0;
    results_owed = 0;
  end

  task automatic clear_servo();
    for (int n = 0; n < NUM_CH; n++) begin
      target_mem[n] = '0;
      capture_mem[n] = '0;
    end
    tick_count = '0;
    frame_ph = PH_IDLE;
    seen_low = '0;
    line_mask = '1;
    tpu_reg = TPU_RESET;
    end_reg = FRAME_END_RESET;
  endtask

  function automatic logic [CNT_W-1:0] scaled_us(input int us);
    return CNT_W'(us * int'(tpu_reg));
  endfunction

  function automatic logic [PIN_W-1:0] reached_mask(input logic [CNT_W-1:0] cnt);
    logic [PIN_W-1:0] m;
    m = '0;
    for (int n = 0; n < NUM_CH; n++)
      if (target_mem[n] <= cnt) m[n] = 1'b1;
    return m;
  endfunction

  task automatic tick_servo(input logic [PIN_W-1:0] pins);
    logic [CNT_W-1:0] t_sample, t_offset, t_end;
    logic [PIN_W-1:0] fresh;
    if (frame_ph == PH_IDLE) return;
    tick_count = tick_count + 1'b1;
    if (frame_ph == PH_OUT) begin
      line_mask |= reached_mask(tick_count);
      if (tick_count >= end_reg) begin
        line_mask = '1;
        frame_ph = PH_IDLE;
      end
      return;
    end
    t_sample = scaled_us(US_SAMPLE);
    t_offset = scaled_us(US_OFFSET);
    t_end = t_sample + scaled_us(US_SPAN);
    if (tick_count >= t_end) begin
      for (int n = 0; n < NUM_CH; n++)
        if (!seen_low[n]) capture_mem[n] = '0 - t_offset;
      line_mask = '1;
      frame_ph = PH_IDLE;
    end else if (tick_count >= t_sample) begin
      fresh = ~pins & ~seen_low;
      for (int n = 0; n < NUM_CH; n++)
        if (fresh[n]) capture_mem[n] = tick_count - t_offset;
      seen_low |= fresh;
    end else if (tick_count >= scaled_us(US_PULL)) begin
      line_mask = '0;
    end else if (tick_count >= scaled_us(US_RELEASE)) begin
      line_mask = '1;
    end
  endtask

  task automatic advance_servo(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                               input logic [POS_W-1:0] pos, input logic [PIN_W-1:0] pins,
                               output result_t r);
    logic busy;
    logic [CNT_W-1:0] rd;
    logic rej;
    busy = (frame_ph != PH_IDLE);
    rd = '0;
    rej = 1'b0;
    case (op)
      OP_SET_TARGET: begin
        if (busy || ch >= NUM_CH) rej = 1'b1;
        else target_mem[ch] = pos;
      end
      OP_START_OUTPUT: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          tick_count = '0;
          frame_ph = PH_OUT;
          line_mask = reached_mask('0);
        end
      end
      OP_START_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          tick_count = '0;
          frame_ph = PH_READ;
          line_mask = '0;
          seen_low = '0;
        end
      end
      OP_TICK: tick_servo(pins);
      OP_READ_CAPTURE: begin
        if (busy || ch >= NUM_CH) rej = 1'b1;
        else rd = capture_mem[ch];
      end
      default: ;
    endcase
    r.drive_low = line_mask;
    r.phase = frame_ph;
    r.read_value = rd;
    r.rejected = rej;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %h actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      clear_servo();
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICKS_PER_US: tpu_reg = cfg_data[TPU_W-1:0];
          CFG_FRAME_END:    end_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        advance_servo(s_tuser, s_tdata[4:0], s_tdata[20:5], s_tdata[44:21], want);
        results_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.drive_low = m_tdata[23:0];
        got.phase = m_tdata[25:24];
        got.read_value = m_tdata[41:26];
        got.rejected = m_tuser;
        if (results_due.size() == 0) begin
          $error("result beat with nothing pending: drive_low %h phase %0d read_value %h",
                 got.drive_low, got.phase, got.read_value);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("drive_low", 32'(want.drive_low), 32'(got.drive_low));
          check_field("phase", 32'(want.phase), 32'(got.phase));
          check_field("read_value", 32'(want.read_value), 32'(got.read_value));
          check_field("rejected", 32'(want.rejected), 32'(got.rejected));
        end
      end
    end
    results_owed = results_due.size();
  end

endmodule

// File: tb/tb_top.sv
// tb_top: clock, reset, request and result traffic and the verdict for the servo block
// depends on spg_pkg, servo_pulse_generator_readback and servo_frame_checker
`timescale 1ns / 1ps

module tb_top import spg_pkg::*; ();

  localparam int NUM_CH = NUM_CHANNELS_DEF;
  // long receiver hold-off, so the request side backs up
  localparam int HOLD_CYCLES = 300;
  localparam int EPISODES_PER_MODE = 10;
  // wait for stray beats once every result beat is back
  localparam int DRAIN_CYCLES = 10;
  // sampling of a readback frame ends this many us after its start
  localparam int US_READ_END = 2800;
  localparam logic [OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [CNT_W-1:0] END_LONG = 16'd100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;        // channel, target_position, pin_levels, zero pad
  logic [OP_W-1:0]      s_tuser = OP_TICK;   // operation
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;             // drive_low, phase, read_value, zero pad
  logic                 m_tuser;             // rejected
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TICKS_PER_US;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int results_owed;

  // idle rates in percent, and the hold-off counter of the result side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  // register values as last written, used to know how long a frame runs and to pick targets
  logic [TPU_W-1:0] cur_tpu = TPU_RESET;
  logic [CNT_W-1:0] cur_end = FRAME_END_RESET;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  servo_pulse_generator_readback dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  servo_frame_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // result side: a pending hold-off wins, otherwise ready follows the idle rate
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      m_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one request beat; random gaps before it, then hold it until taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [POS_W-1:0] pos, input logic [PIN_W-1:0] pins);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'b000, pins, pos, ch};
    do @(posedge clk); while (!s_tready);
  endtask

  // register write once every result beat is back; callers issue it with no frame running
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICKS_PER_US) cur_tpu = val[TPU_W-1:0];
    else cur_end = val;
  endtask

  // mostly valid channels, now and then one out of range (24 to 31)
  function automatic logic [CH_W-1:0] rand_channel();
    if ($urandom_range(7) == 0) return CH_W'($urandom_range(31, NUM_CH));
    return CH_W'($urandom_range(NUM_CH - 1));
  endfunction

  // targets mostly within the frame length (up to 8 past it), so channels drop at varied ticks
  function automatic logic [POS_W-1:0] rand_target();
    if ($urandom_range(3) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(int'(cur_end) + 8));
  endfunction

  // pin levels that go low rarely: each line low with odds of 1 in 2^k
  function automatic logic [PIN_W-1:0] sample_pins(input int k);
    logic [PIN_W-1:0] lows;
    lows = '1;
    repeat (k) lows &= PIN_W'($urandom);
    return ~lows;
  endfunction

  // ticks until a frame started now goes idle again
  function automatic int frame_ticks(input bit readback);
    int span;
    span = readback ? ((US_READ_END * int'(cur_tpu)) % 65536) : int'(cur_end);
    return (span == 0) ? 1 : span;
  endfunction

  // a request that a running frame turns away, or a spare code
  task automatic send_noise();
    logic [OP_W-1:0] op;
    case ($urandom_range(5))
      0: op = OP_SET_TARGET;
      1: op = OP_START_OUTPUT;
      2: op = OP_START_READ;
      3: op = OP_READ_CAPTURE;
      default: op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    endcase
    send_item(op, rand_channel(), rand_target(), PIN_W'($urandom));
  endtask

  // start a frame and tick it to its end, with stray requests in between
  task automatic run_frame(input bit readback, input bit noisy);
    int ticks;
    int low_odds;
    low_odds = $urandom_range(10, 3);
    send_item(readback ? OP_START_READ : OP_START_OUTPUT, rand_channel(), rand_target(),
              PIN_W'($urandom));
    ticks = frame_ticks(readback);
    for (int i = 0; i < ticks; i++) begin
      if (noisy && $urandom_range(15) == 0) send_noise();
      send_item(OP_TICK, rand_channel(), rand_target(), sample_pins(low_odds));
    end
    // ticks after the end must leave everything alone
    repeat ($urandom_range(2)) send_item(OP_TICK, rand_channel(), rand_target(),
                                         PIN_W'($urandom));
  endtask

  // idle setup traffic, one frame, then some capture reads
  task automatic run_episode();
    bit readback;
    readback = ($urandom_range(9) < 4);
    if (readback) begin
      // short readback frames: with all window edges at zero the first tick ends them
      write_reg(CFG_TICKS_PER_US, '0);
    end else begin
      if ($urandom_range(2) == 0)
        write_reg(CFG_FRAME_END, CFG_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1)));
      if ($urandom_range(3) == 0)
        write_reg(CFG_TICKS_PER_US, CFG_W'($urandom_range(31)));
    end
    repeat ($urandom_range(10, 1)) begin
      case ($urandom_range(5))
        0, 1, 2: send_item(OP_SET_TARGET, rand_channel(), rand_target(), PIN_W'($urandom));
        3: send_item(OP_READ_CAPTURE, rand_channel(), rand_target(), PIN_W'($urandom));
        4: send_item(OP_TICK, rand_channel(), rand_target(), PIN_W'($urandom));
        default: send_item(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                           rand_channel(), rand_target(), PIN_W'($urandom));
      endcase
    end
    run_frame(readback, 1'b1);
    repeat ($urandom_range(6, 2))
      send_item(OP_READ_CAPTURE, rand_channel(), rand_target(), PIN_W'($urandom));
  endtask

  // one idling mode; opens with a long result-side hold-off under steady requests
  task automatic run_mode(input int snd_pct, input int rcv_pct);
    @(posedge clk);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    recv_hold = HOLD_CYCLES;
    repeat (20) send_item(OP_READ_CAPTURE, rand_channel(), rand_target(), PIN_W'($urandom));
    repeat (EPISODES_PER_MODE) run_episode();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part: windows all at zero, a three-tick output frame
    write_reg(CFG_TICKS_PER_US, '0);
    write_reg(CFG_FRAME_END, CFG_W'(3));
    send_item(OP_READ_CAPTURE, 5'd0, '0, '0);          // capture still at reset
    send_item(OP_SET_TARGET, 5'd0, '0, '0);            // zero target drops at frame start
    send_item(OP_SET_TARGET, 5'd23, '1, '1);           // top channel, largest width
    send_item(OP_SET_TARGET, 5'd31, 16'd1234, '0);     // channel out of range
    send_item(OP_SET_TARGET, 5'd1, 16'd2, '0);
    send_item(OP_READ_CAPTURE, 5'd24, '0, '0);         // first channel out of range
    send_item(OP_SPARE_FIRST, 5'd3, '1, '1);
    send_item(OP_SPARE_LAST, 5'd3, '0, '0);
    send_item(OP_TICK, 5'd0, '0, '0);                  // tick while idle
    send_item(OP_START_OUTPUT, 5'd0, '0, '0);
    // set target, start and read capture are turned away while the frame runs
    send_item(OP_SET_TARGET, 5'd2, 16'd7, '0);
    send_item(OP_START_READ, 5'd0, '0, '0);
    send_item(OP_READ_CAPTURE, 5'd0, '0, '0);
    send_item(OP_START_OUTPUT, 5'd0, '0, '0);
    send_item(OP_TICK, 5'd0, '0, '0);
    send_item(OP_TICK, 5'd0, '0, '1);                  // channel 1 reaches its target
    send_item(OP_TICK, 5'd0, '0, PIN_W'($urandom));    // frame end forces all low
    send_item(OP_START_READ, 5'd0, '0, '0);
    send_item(OP_TICK, 5'd0, '0, '0);                  // zero-length readback ends at once
    send_item(OP_READ_CAPTURE, 5'd23, '0, '0);
    send_item(OP_READ_CAPTURE, 5'd0, '0, '0);
    write_reg(CFG_FRAME_END, '0);                      // end tick of zero
    send_item(OP_START_OUTPUT, 5'd0, '0, '0);
    send_item(OP_TICK, 5'd0, '0, '0);

    // random part under the three idling modes
    run_mode(30, 52);
    run_mode(52, 30);
    run_mode(0, 0);

    // every channel set, a longer output frame, a readback, then all captures read
    write_reg(CFG_FRAME_END, CFG_W'(END_LONG));
    for (int n = 0; n < NUM_CH; n++)
      send_item(OP_SET_TARGET, CH_W'(n), rand_target(), '0);
    run_frame(1'b0, 1'b1);
    write_reg(CFG_TICKS_PER_US, '0);
    run_frame(1'b1, 1'b1);
    for (int n = 0; n < NUM_CH; n++)
      send_item(OP_READ_CAPTURE, CH_W'(n), '0, '0);

    // drain, then allow stray beats to show up
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #200_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
